// ----- rtl/pfa_pkg.sv -----
// pfa_pkg: shared types, codes and defaults of the paged frame allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;

  localparam int NUM_FRAMES_DEF = 256;
  localparam int MAX_PROCS_DEF  = 16;

  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_RESIDENT = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_RELEASED = 3'd3,
    ST_NOT_RES  = 3'd4,
    ST_ZERO     = 3'd5,
    ST_EVICTED  = 3'd6
  } status_e;

  typedef enum logic {
    REG_FRAME_SHIFT = 1'b0,
    REG_FRAME_COUNT = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SCAN_START, CMD_SCAN_NEXT, CMD_MARK,
    CMD_REL_START, CMD_REL_WR, CMD_REL_LINK, CMD_REL_END,
    CMD_TAKE_START, CMD_TAKE_RD, CMD_TAKE_WR, CMD_TAKE_END, CMD_EMIT
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_FIND, S_CHECK, S_SCAN, S_REL_PRE, S_REL_INIT,
    S_REL_CHK, S_REL_LINK, S_TAKE_CHK, S_TAKE_WR, S_EMIT
  } state_e;

  typedef struct packed {
    cmd_e    op;
    status_e st;
    logic    last;
  } pfa_cmd_t;

  typedef struct packed {
    logic req_type;
    logic pid_oor;
    logic resident;
    logic need_zero;
    logic short_free;
    logic scan_end;
    logic scan_hit;
    logic scan_match;
    logic rel_done;
    logic take_done;
    logic out_free;
  } pfa_stat_t;

endpackage
`default_nettype wire

// ----- rtl/pfa_if.sv -----
// pfa_req_if / pfa_rsp_if: valid/ready channels of the allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface pfa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  process_id;
  logic [23:0] memory_required;
  logic [15:0] busy_mask;
  modport source (output valid, req_type, process_id, memory_required, busy_mask,
                  input ready);
  modport sink   (input valid, req_type, process_id, memory_required, busy_mask,
                  output ready);
endinterface

interface pfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  subject_process;
  logic [23:0] start_address;
  logic        last;
  logic [31:0] pages_in_total;
  logic [31:0] pages_out_total;
  logic [8:0]  frames_in_use;
  modport source (output valid, status, subject_process, start_address, last,
                  pages_in_total, pages_out_total, frames_in_use, input ready);
  modport sink   (input valid, status, subject_process, start_address, last,
                  pages_in_total, pages_out_total, frames_in_use, output ready);
endinterface
`default_nettype wire

// ----- rtl/pfa_ctrl.sv -----
// pfa_ctrl: request sequencer; issues datapath commands.
// Depends on pfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire pfa_pkg::pfa_stat_t stat_i,
  output pfa_pkg::pfa_cmd_t      cmd_o
);

  pfa_pkg::state_e  state_q, state_d;
  pfa_pkg::status_e st_q, st_d;
  logic             last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::S_IDLE;
      st_q    <= pfa_pkg::ST_ALLOC;
      last_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: pfa_pkg::CMD_NONE, st: st_q, last: last_q};
    case (state_q)
      pfa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = pfa_pkg::CMD_LOAD;
          state_d  = pfa_pkg::S_DECIDE;
        end
      end
      pfa_pkg::S_DECIDE: begin
        last_d = 1'b1;
        if (stat_i.req_type) begin
          if (stat_i.pid_oor || !stat_i.resident) begin
            st_d    = pfa_pkg::ST_NOT_RES;
            state_d = pfa_pkg::S_EMIT;
          end else begin
            cmd_o.op = pfa_pkg::CMD_SCAN_START;
            state_d  = pfa_pkg::S_FIND;
          end
        end else if (stat_i.pid_oor) begin
          st_d    = pfa_pkg::ST_NO_SPACE;
          state_d = pfa_pkg::S_EMIT;
        end else if (stat_i.resident) begin
          st_d    = pfa_pkg::ST_RESIDENT;
          state_d = pfa_pkg::S_EMIT;
        end else if (stat_i.need_zero) begin
          st_d    = pfa_pkg::ST_ZERO;
          state_d = pfa_pkg::S_EMIT;
        end else begin
          state_d = pfa_pkg::S_CHECK;
        end
      end
      pfa_pkg::S_FIND: begin
        if (stat_i.scan_end) begin
          state_d = pfa_pkg::S_REL_PRE;
        end else if (stat_i.scan_match) begin
          cmd_o.op = pfa_pkg::CMD_MARK;
          state_d  = pfa_pkg::S_REL_PRE;
        end else begin
          cmd_o.op = pfa_pkg::CMD_SCAN_NEXT;
        end
      end
      pfa_pkg::S_CHECK: begin
        if (stat_i.short_free) begin
          cmd_o.op = pfa_pkg::CMD_SCAN_START;
          state_d  = pfa_pkg::S_SCAN;
        end else begin
          cmd_o.op = pfa_pkg::CMD_TAKE_START;
          state_d  = pfa_pkg::S_TAKE_CHK;
        end
      end
      pfa_pkg::S_SCAN: begin
        if (stat_i.scan_end) begin
          st_d    = pfa_pkg::ST_NO_SPACE;
          last_d  = 1'b1;
          state_d = pfa_pkg::S_EMIT;
        end else if (stat_i.scan_hit) begin
          cmd_o.op = pfa_pkg::CMD_MARK;
          state_d  = pfa_pkg::S_REL_PRE;
        end else begin
          cmd_o.op = pfa_pkg::CMD_SCAN_NEXT;
        end
      end
      pfa_pkg::S_REL_PRE: state_d = pfa_pkg::S_REL_INIT;
      pfa_pkg::S_REL_INIT: begin
        cmd_o.op = pfa_pkg::CMD_REL_START;
        state_d  = pfa_pkg::S_REL_CHK;
      end
      pfa_pkg::S_REL_CHK: begin
        if (stat_i.rel_done) begin
          cmd_o.op = pfa_pkg::CMD_REL_END;
          st_d     = stat_i.req_type ? pfa_pkg::ST_RELEASED : pfa_pkg::ST_EVICTED;
          last_d   = stat_i.req_type;
          state_d  = pfa_pkg::S_EMIT;
        end else begin
          cmd_o.op = pfa_pkg::CMD_REL_WR;
          state_d  = pfa_pkg::S_REL_LINK;
        end
      end
      pfa_pkg::S_REL_LINK: begin
        cmd_o.op = pfa_pkg::CMD_REL_LINK;
        state_d  = pfa_pkg::S_REL_CHK;
      end
      pfa_pkg::S_TAKE_CHK: begin
        if (stat_i.take_done) begin
          cmd_o.op = pfa_pkg::CMD_TAKE_END;
          st_d     = pfa_pkg::ST_ALLOC;
          last_d   = 1'b1;
          state_d  = pfa_pkg::S_EMIT;
        end else begin
          cmd_o.op = pfa_pkg::CMD_TAKE_RD;
          state_d  = pfa_pkg::S_TAKE_WR;
        end
      end
      pfa_pkg::S_TAKE_WR: begin
        cmd_o.op = pfa_pkg::CMD_TAKE_WR;
        state_d  = pfa_pkg::S_TAKE_CHK;
      end
      pfa_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = pfa_pkg::CMD_EMIT;
          state_d  = last_q ? pfa_pkg::S_IDLE : pfa_pkg::S_CHECK;
        end
      end
      default: state_d = pfa_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pfa_dp.sv -----
// pfa_dp: free list, frame links, process tables, age order, counters, result register.
// Depends on pfa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfa_dp #(
  parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
  parameter int MAX_PROCS  = pfa_pkg::MAX_PROCS_DEF,
  localparam int FW = $clog2(NUM_FRAMES),
  localparam int CW = $clog2(NUM_FRAMES + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pfa_pkg::pfa_cmd_t  cmd_i,
  output pfa_pkg::pfa_stat_t      stat_o,
  input  wire logic               init_i,
  input  wire logic [CW-1:0]      init_count_i,
  input  wire logic [CW-1:0]      frame_count_i,
  input  wire logic [4:0]         frame_shift_i,
  input  wire logic               req_type_i,
  input  wire logic [3:0]         process_id_i,
  input  wire logic [23:0]        memory_required_i,
  input  wire logic [15:0]        busy_mask_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic [2:0]              status_o,
  output logic [3:0]              subject_process_o,
  output logic [23:0]             start_address_o,
  output logic                    last_o,
  output logic [31:0]             pages_in_total_o,
  output logic [31:0]             pages_out_total_o,
  output logic [8:0]              frames_in_use_o
);

  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int LW = $clog2(MAX_PROCS + 1);
  localparam logic [CW:0] NF = (CW+1)'(NUM_FRAMES);
  localparam logic [CW-1:0] FC_RST = CW'((NUM_FRAMES < 256) ? NUM_FRAMES : 256);

  logic [FW-1:0] fifo_mem  [NUM_FRAMES];
  logic [FW-1:0] link_mem  [NUM_FRAMES];
  logic [FW-1:0] first_mem [MAX_PROCS];
  logic [PW-1:0] age_q     [MAX_PROCS];
  logic [CW-1:0] tot_q     [MAX_PROCS];

  logic [FW-1:0] head_q, f_q, prev_q, first_f_q, fifo_rd_q, link_rd_q, first_rd_q, rd_idx_q;
  logic [CW-1:0] cnt_q, fill_q, use_q, k_q, n_q;
  logic [LW-1:0] len_q, idx_q, pos_q;
  logic          found_q, written_q;
  logic [31:0]   pin_q, pout_q;
  logic          req_q;
  logic [3:0]    pid_q;
  logic [PW-1:0] vic_q;
  logic [23:0]   need_q;
  logic [15:0]   busy_q;

  logic [CW:0]   tsum, tfull, osum, ofull;
  logic [FW-1:0] tail, head_inc;
  logic [CW-1:0] hsum;
  logic [PW-1:0] age_rd;
  logic          busy_bit, pid_oor;
  logic [39:0]   addr_src;

  assign tsum  = (CW+1)'(head_q) + (CW+1)'(cnt_q);
  assign tfull = (tsum >= NF) ? tsum - NF : tsum;
  assign tail  = tfull[FW-1:0];
  assign hsum  = CW'(head_q) + CW'(1);
  assign head_inc = (hsum == CW'(NUM_FRAMES)) ? '0 : hsum[FW-1:0];
  // offset of head from the first slot past the initial list
  assign osum  = (CW+1)'(head_q) + NF - (CW+1)'(frame_count_i);
  assign ofull = (osum >= NF) ? osum - NF : osum;

  assign age_rd   = age_q[idx_q[PW-1:0]];
  assign busy_bit = (32'(age_rd) < 16) ? busy_q[4'(age_rd)] : 1'b0;
  assign pid_oor  = 32'(pid_q) >= MAX_PROCS;

  always_comb begin
    stat_o.req_type   = req_q;
    stat_o.pid_oor    = pid_oor;
    stat_o.resident   = tot_q[vic_q] != '0;
    stat_o.need_zero  = need_q == '0;
    stat_o.short_free = 24'(cnt_q) < need_q;
    stat_o.scan_end   = idx_q == len_q;
    stat_o.scan_hit   = !busy_bit;
    stat_o.scan_match = age_rd == vic_q;
    stat_o.rel_done   = (k_q >= n_q) || (cnt_q == CW'(NUM_FRAMES));
    stat_o.take_done  = 24'(k_q) == need_q;
    stat_o.out_free   = !out_valid_o || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    first_rd_q <= first_mem[vic_q];
    if (cmd_i.op == pfa_pkg::CMD_REL_WR) begin
      fifo_mem[tail] <= f_q;
      link_rd_q      <= link_mem[f_q];
    end
    if (cmd_i.op == pfa_pkg::CMD_TAKE_RD) begin
      fifo_rd_q <= fifo_mem[head_q];
      rd_idx_q  <= head_q;
      written_q <= ofull < (CW+1)'(fill_q);
    end
    if (cmd_i.op == pfa_pkg::CMD_TAKE_WR) begin
      if (k_q == '0) first_mem[PW'(pid_q)] <= written_q ? fifo_rd_q : rd_idx_q;
      else           link_mem[prev_q]      <= written_q ? fifo_rd_q : rd_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pfa_pkg::CMD_LOAD: begin
        pid_q  <= process_id_i;
        vic_q  <= PW'(process_id_i);
        need_q <= memory_required_i >> frame_shift_i;
        busy_q <= busy_mask_i;
      end
      pfa_pkg::CMD_MARK: begin
        vic_q <= age_rd;
        pos_q <= idx_q;
      end
      pfa_pkg::CMD_REL_START: begin
        f_q <= first_rd_q;
        n_q <= tot_q[vic_q];
      end
      pfa_pkg::CMD_REL_LINK: f_q <= link_rd_q;
      pfa_pkg::CMD_TAKE_WR: begin
        prev_q <= written_q ? fifo_rd_q : rd_idx_q;
        if (k_q == '0) first_f_q <= written_q ? fifo_rd_q : rd_idx_q;
      end
      pfa_pkg::CMD_REL_END: begin
        for (int j = 0; j < MAX_PROCS - 1; j++) begin
          if (found_q && LW'(j) >= pos_q && LW'(j) + LW'(1) < len_q) age_q[j] <= age_q[j+1];
        end
      end
      pfa_pkg::CMD_TAKE_END: begin
        if (len_q < LW'(MAX_PROCS)) age_q[len_q[PW-1:0]] <= PW'(pid_q);
      end
      default: ;
    endcase
    if (cmd_i.op == pfa_pkg::CMD_EMIT && !(out_valid_o && !out_ready_i)) begin
      status_o          <= cmd_i.st;
      subject_process_o <= (cmd_i.st == pfa_pkg::ST_EVICTED) ? 4'(vic_q) : pid_q;
      start_address_o   <= addr_src[23:0];
      last_o            <= cmd_i.last;
      pages_in_total_o  <= pin_q;
      pages_out_total_o <= pout_q;
      frames_in_use_o   <= 9'(use_q);
    end
  end

  always_comb begin
    case (cmd_i.st)
      pfa_pkg::ST_ALLOC:    addr_src = 40'(first_f_q) << frame_shift_i;
      pfa_pkg::ST_RESIDENT: addr_src = 40'(first_rd_q) << frame_shift_i;
      default:              addr_src = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= FC_RST;
      fill_q      <= '0;
      use_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      pin_q       <= '0;
      pout_q      <= '0;
      req_q       <= 1'b0;
      out_valid_o <= 1'b0;
      for (int i = 0; i < MAX_PROCS; i++) tot_q[i] <= '0;
    end else begin
      if (out_ready_i && cmd_i.op != pfa_pkg::CMD_EMIT) out_valid_o <= 1'b0;
      if (init_i) begin
        head_q  <= '0;
        cnt_q   <= init_count_i;
        fill_q  <= '0;
        use_q   <= '0;
        len_q   <= '0;
        for (int i = 0; i < MAX_PROCS; i++) tot_q[i] <= '0;
      end else begin
        case (cmd_i.op)
          pfa_pkg::CMD_LOAD: req_q <= req_type_i;
          pfa_pkg::CMD_SCAN_START: begin
            idx_q   <= '0;
            found_q <= 1'b0;
          end
          pfa_pkg::CMD_SCAN_NEXT: idx_q <= idx_q + LW'(1);
          pfa_pkg::CMD_MARK: found_q <= 1'b1;
          pfa_pkg::CMD_REL_START: k_q <= '0;
          pfa_pkg::CMD_REL_WR: begin
            cnt_q  <= cnt_q + CW'(1);
            pout_q <= pout_q + 32'd1;
            k_q    <= k_q + CW'(1);
            if (fill_q != CW'(NUM_FRAMES)) fill_q <= fill_q + CW'(1);
          end
          pfa_pkg::CMD_REL_END: begin
            tot_q[vic_q] <= '0;
            use_q        <= use_q - n_q;
            if (found_q) len_q <= len_q - LW'(1);
          end
          pfa_pkg::CMD_TAKE_START: k_q <= '0;
          pfa_pkg::CMD_TAKE_WR: begin
            head_q <= head_inc;
            cnt_q  <= cnt_q - CW'(1);
            pin_q  <= pin_q + 32'd1;
            k_q    <= k_q + CW'(1);
          end
          pfa_pkg::CMD_TAKE_END: begin
            tot_q[PW'(pid_q)] <= CW'(need_q);
            use_q             <= use_q + CW'(need_q);
            if (len_q < LW'(MAX_PROCS)) len_q <= len_q + LW'(1);
          end
          pfa_pkg::CMD_EMIT: out_valid_o <= 1'b1;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/paged_frame_allocator_oldest_swap.sv -----
// Paged frame allocator with oldest-first swap-out: top level, APB registers.
// Depends on pfa_pkg, pfa_if, pfa_ctrl, pfa_dp.
//
//  channel   dir  handshake                    payload
//  req_i     in   valid/ready                  req_type, process_id, memory_required, busy_mask
//  rsp_o     out  valid/ready                  status ... frames_in_use (one per record)
//  apb       in   psel/penable/pwrite, pready  frame_shift @0x0, frame_count @0x4
//
// One request at a time; a plain answer goes through S_DECIDE and S_EMIT into the rsp_o register.
// Release: the age scan (S_FIND), S_REL_PRE, S_REL_INIT, then S_REL_CHK and S_REL_LINK per frame.
// Eviction: S_SCAN, then the release states; take: S_TAKE_CHK and S_TAKE_WR per frame.
// rsp_o is registered; a stalled rsp_o holds the sequencer at its next record.
// Reset is asynchronous and leaves frames 0..frame_count-1 free; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module paged_frame_allocator_oldest_swap #(
  parameter int NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF,
  parameter int MAX_PROCS  = pfa_pkg::MAX_PROCS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pfa_req_if.sink          req_i,
  pfa_rsp_if.source        rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam logic [CW-1:0] FC_RST = CW'((NUM_FRAMES < 256) ? NUM_FRAMES : 256);

  logic [4:0]    shift_q;
  logic [CW-1:0] fc_q, fc_d;
  logic          wr, init;
  pfa_pkg::pfa_cmd_t  cmd;
  pfa_pkg::pfa_stat_t stat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign init   = wr && (paddr[2] == pfa_pkg::REG_FRAME_COUNT);
  assign fc_d   = (pwdata == 32'd0) ? CW'(1) :
                  (pwdata > 32'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(pwdata);
  assign prdata = (paddr[2] == pfa_pkg::REG_FRAME_COUNT) ? 32'(fc_q) : 32'(shift_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 5'd12;
      fc_q    <= FC_RST;
    end else if (wr) begin
      if (paddr[2] == pfa_pkg::REG_FRAME_SHIFT) begin
        shift_q <= (pwdata > 32'd16) ? 5'd16 : pwdata[4:0];
      end else begin
        fc_q <= fc_d;
      end
    end
  end

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfa_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .MAX_PROCS  (MAX_PROCS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .init_i            (init),
    .init_count_i      (fc_d),
    .frame_count_i     (fc_q),
    .frame_shift_i     (shift_q),
    .req_type_i        (req_i.req_type),
    .process_id_i      (req_i.process_id),
    .memory_required_i (req_i.memory_required),
    .busy_mask_i       (req_i.busy_mask),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .status_o          (rsp_o.status),
    .subject_process_o (rsp_o.subject_process),
    .start_address_o   (rsp_o.start_address),
    .last_o            (rsp_o.last),
    .pages_in_total_o  (rsp_o.pages_in_total),
    .pages_out_total_o (rsp_o.pages_out_total),
    .frames_in_use_o   (rsp_o.frames_in_use)
  );

endmodule
`default_nettype wire

// ----- rtl/pfa_checker.sv -----
// pfa_checker: port-level assertions for the allocator, bound to the top level.
// Depends on pfa_pkg and paged_frame_allocator_oldest_swap.
`timescale 1ns / 1ps
`default_nettype none
module pfa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [23:0] start_address,
  input wire logic        last
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
    else $error("result transaction dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while one is in progress");

  a_last_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !last |-> status == 3'(pfa_pkg::ST_EVICTED))
    else $error("non-final record is not an eviction");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != 3'(pfa_pkg::ST_ALLOC) && status != 3'(pfa_pkg::ST_RESIDENT)
      |-> start_address == 24'd0)
    else $error("address on record without a frame");

endmodule

bind paged_frame_allocator_oldest_swap pfa_checker u_pfa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (req_i.valid),
  .in_ready      (req_i.ready),
  .out_valid     (rsp_o.valid),
  .out_ready     (rsp_o.ready),
  .status        (rsp_o.status),
  .start_address (rsp_o.start_address),
  .last          (rsp_o.last)
);
`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking testbench of paged_frame_allocator_oldest_swap.
// Drives random and directed requests, predicts every record in a behavioral
// allocator model. Depends on pfa_pkg, pfa_if and the RTL.
`timescale 1ns / 1ps
module tb;

  localparam int NF = 256;
  localparam int NP = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  process_id;
    logic [23:0] memory_required;
    logic [15:0] busy_mask;
  } req_t;

  typedef struct packed {
    pfa_pkg::status_e status;
    logic [3:0]       subject_process;
    logic [23:0]      start_address;
    logic             last;
    logic [31:0]      pages_in_total;
    logic [31:0]      pages_out_total;
    logic [8:0]       frames_in_use;
  } rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pfa_req_if req_ch ();
  pfa_rsp_if rsp_ch ();

  paged_frame_allocator_oldest_swap dut (
    .clk_i(clk), .rst_ni(rst_n), .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // allocator shadow state
  logic [7:0]  fifo_q [NF];
  int unsigned head_q, nfree_q;
  logic [7:0]  link_q [NF];
  logic [7:0]  first_q [NP];
  int unsigned held_q [NP];
  logic [3:0]  age_q [NP];
  int unsigned age_len;
  logic [31:0] pin_q, pout_q;
  int unsigned shift_q, fcount_q;

  req_t pending_reqs[$];
  rec_t expected_recs[$];
  int   errors = 0;
  int   n_sent = 0, n_recs = 0, n_evict = 0;
  int   send_idle_pct = 0, recv_stall_pct = 0;
  bit   hold_recv = 1'b0;

  function automatic void queue_req(req_t rq);
    pending_reqs = {pending_reqs, rq};
  endfunction

  function automatic void reset_pool();
    head_q = 0;
    nfree_q = fcount_q;
    for (int i = 0; i < NF; i++) begin
      fifo_q[i] = (i < fcount_q) ? i[7:0] : 8'd0;
      link_q[i] = '0;
    end
    for (int i = 0; i < NP; i++) begin
      first_q[i] = '0;
      held_q[i] = 0;
      age_q[i] = '0;
    end
    age_len = 0;
  endfunction

  function automatic void push_rec(pfa_pkg::status_e st, logic [3:0] subj, logic [23:0] addr,
                                   logic lst);
    rec_t r;
    int unsigned used;
    used = 0;
    for (int i = 0; i < NP; i++) used += held_q[i];
    r.status = st;
    r.subject_process = subj;
    r.start_address = addr;
    r.last = lst;
    r.pages_in_total = pin_q;
    r.pages_out_total = pout_q;
    r.frames_in_use = used[8:0];
    expected_recs = {expected_recs, r};
  endfunction

  function automatic void free_frames(int unsigned p);
    int unsigned f, n;
    f = first_q[p];
    n = held_q[p];
    for (int k = 0; k < n && nfree_q < NF; k++) begin
      fifo_q[(head_q + nfree_q) % NF] = f[7:0];
      nfree_q++;
      pout_q++;
      f = link_q[f];
    end
    held_q[p] = 0;
    for (int i = 0; i < age_len; i++) begin
      if (age_q[i] == p) begin
        for (int j = i; j + 1 < age_len; j++) age_q[j] = age_q[j + 1];
        age_len--;
        break;
      end
    end
  endfunction

  function automatic void predict_request(req_t rq);
    int unsigned pid, need, victim, k, f, prev;
    bit found;
    logic [47:0] addr;
    pid = rq.process_id;
    k = 0;
    if (rq.req_type) begin
      if (held_q[pid] == 0) begin
        push_rec(pfa_pkg::ST_NOT_RES, rq.process_id, '0, 1'b1);
      end else begin
        free_frames(pid);
        push_rec(pfa_pkg::ST_RELEASED, rq.process_id, '0, 1'b1);
      end
      return;
    end
    if (held_q[pid] != 0) begin
      addr = 48'(first_q[pid]) << shift_q;
      push_rec(pfa_pkg::ST_RESIDENT, rq.process_id, addr[23:0], 1'b1);
      return;
    end
    need = rq.memory_required >> shift_q;
    if (need == 0) begin
      push_rec(pfa_pkg::ST_ZERO, rq.process_id, '0, 1'b1);
      return;
    end
    while (nfree_q < need) begin
      found = 1'b0;
      victim = 0;
      for (int i = 0; i < age_len; i++) begin
        if (!rq.busy_mask[age_q[i]]) begin
          victim = age_q[i];
          found = 1'b1;
          break;
        end
      end
      if (!found || k >= NP) begin
        push_rec(pfa_pkg::ST_NO_SPACE, rq.process_id, '0, 1'b1);
        return;
      end
      free_frames(victim);
      push_rec(pfa_pkg::ST_EVICTED, victim[3:0], '0, 1'b0);
      k++;
    end
    prev = 0;
    for (int j = 0; j < need; j++) begin
      f = fifo_q[head_q];
      head_q = (head_q + 1) % NF;
      nfree_q--;
      if (j == 0) first_q[pid] = f[7:0];
      else link_q[prev] = f[7:0];
      prev = f;
      pin_q++;
    end
    held_q[pid] = need;
    if (age_len < NP) begin
      age_q[age_len] = pid[3:0];
      age_len++;
    end
    addr = 48'(first_q[pid]) << shift_q;
    push_rec(pfa_pkg::ST_ALLOC, rq.process_id, addr[23:0], 1'b1);
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= 1'b0;
      req_ch.process_id <= '0;
      req_ch.memory_required <= '0;
      req_ch.busy_mask <= '0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        predict_request({req_ch.req_type, req_ch.process_id, req_ch.memory_required,
                         req_ch.busy_mask});
        n_sent++;
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_t rq;
        rq = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        {req_ch.req_type, req_ch.process_id, req_ch.memory_required,
         req_ch.busy_mask} <= rq;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rec_t got, exp_r;
        got = {pfa_pkg::status_e'(rsp_ch.status), rsp_ch.subject_process,
               rsp_ch.start_address, rsp_ch.last, rsp_ch.pages_in_total,
               rsp_ch.pages_out_total, rsp_ch.frames_in_use};
        n_recs++;
        if (got.status == pfa_pkg::ST_EVICTED) n_evict++;
        if (expected_recs.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction: %p", got);
        end else begin
          exp_r = expected_recs.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
      end
      rsp_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic apb_write(pfa_pkg::reg_e idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == pfa_pkg::REG_FRAME_SHIFT) begin
      shift_q = (val > 16) ? 16 : val;
    end else begin
      fcount_q = (val == 0) ? 1 : (val > NF) ? NF : val;
      reset_pool();
    end
  endtask

  // waits until every request is sent and every record has been taken
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() != 0 || req_ch.valid || expected_recs.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic req_t mk(logic rt, logic [3:0] p, logic [23:0] m, logic [15:0] b);
    return {rt, p, m, b};
  endfunction

  // mostly allocate/free of small processes, busy masks random in part
  task automatic add_random(int n);
    int unsigned sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 60)
        queue_req(mk(1'b0, 4'($urandom_range(15)),
                     24'(($urandom_range(1, 12) << shift_q) |
                         ($urandom & ((32'd1 << shift_q) - 32'd1))),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0));
      else if (sel < 85)
        queue_req(mk(1'b1, 4'($urandom_range(15)), 24'($urandom), 16'($urandom)));
      else
        queue_req(mk(1'b0, 4'($urandom_range(15)), 24'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    shift_q = 12; fcount_q = NF; pin_q = '0; pout_q = '0;
    reset_pool();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small pool to force evictions and no-space
    apb_write(pfa_pkg::REG_FRAME_SHIFT, 32'd0);
    apb_write(pfa_pkg::REG_FRAME_COUNT, 32'd8);
    queue_req(mk(1'b0, 4'd0, 24'd0, 16'h0));
    queue_req(mk(1'b1, 4'd1, 24'd0, 16'h0));
    queue_req(mk(1'b0, 4'd1, 24'd3, 16'h0));
    queue_req(mk(1'b0, 4'd2, 24'd4, 16'h0));
    queue_req(mk(1'b0, 4'd1, 24'hFFFFFF, 16'h0));
    queue_req(mk(1'b0, 4'd15, 24'd1, 16'hFFFF));
    queue_req(mk(1'b0, 4'd3, 24'd5, 16'h0004));
    queue_req(mk(1'b0, 4'd4, 24'd8, 16'hFFFF));
    queue_req(mk(1'b0, 4'd4, 24'd100, 16'h0));
    queue_req(mk(1'b1, 4'd2, 24'd0, 16'h0));
    queue_req(mk(1'b1, 4'd15, 24'hFFFFFF, 16'hFFFF));
    drain();
    apb_write(pfa_pkg::REG_FRAME_COUNT, 32'd0);
    queue_req(mk(1'b0, 4'd5, 24'd1, 16'h0));
    queue_req(mk(1'b0, 4'd6, 24'd1, 16'h0));
    queue_req(mk(1'b0, 4'd7, 24'd2, 16'h0));
    drain();
    apb_write(pfa_pkg::REG_FRAME_SHIFT, 32'd31);
    apb_write(pfa_pkg::REG_FRAME_COUNT, 32'h1FF);
    queue_req(mk(1'b0, 4'd8, 24'hFFFFFF, 16'h0));
    queue_req(mk(1'b0, 4'd9, 24'h00FFFF, 16'h0));
    queue_req(mk(1'b1, 4'd8, 24'd0, 16'h0));
    drain();
    // 16 frames, all taken by 16 one-frame processes, then a 16-frame request by resident process 0
    apb_write(pfa_pkg::REG_FRAME_SHIFT, 32'd0);
    apb_write(pfa_pkg::REG_FRAME_COUNT, 32'd16);
    for (int i = 0; i < 16; i++) queue_req(mk(1'b0, i[3:0], 24'd1, 16'h0));
    queue_req(mk(1'b0, 4'd0, 24'd16, 16'h0));
    drain();

    // random phases across idling profiles and settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 18 : 73) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 18 : 73) : 0;
      apb_write(pfa_pkg::REG_FRAME_SHIFT, $urandom_range(0, 16));
      apb_write(pfa_pkg::REG_FRAME_COUNT, ph == 0 ? 32'd256 : $urandom_range(1, 64));
      add_random(40);
      if (ph == 0) begin
        hold_recv = 1'b1;
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    apb_write(pfa_pkg::REG_FRAME_SHIFT, 32'd12);
    apb_write(pfa_pkg::REG_FRAME_COUNT, 32'd1);
    add_random(15);
    drain();

    $display("covered %0d requests, %0d records, %0d evictions", n_sent, n_recs, n_evict);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
